// ===== rtl/stbs_pkg.sv =====
// Shared types, constants and helpers for the sorted table binary search block.
`default_nettype none

package stbs_pkg;

   // Fixed field widths.
   localparam int POS_W   = 10;
   localparam int COUNT_W = 11;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int DEFAULT_KEY_BITS    = 32;

   // Entries in the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Command codes of a request.
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Decoded operation handed from the front to the back.
   typedef struct packed {
      logic is_lookup;
      logic write_ok;
   } stbs_op_type;

   // Search sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_PROBE,
      ST_CHK_START,
      ST_CHK_END,
      ST_RESULT
   } stbs_state_type;

   // Width of a signed table index: it must hold the entry count in use,
   // one past it and minus one.
   function automatic int stbs_index_bits(input int depth);
      int aw1;
      aw1 = $clog2(depth) + 1;
      return ((aw1 < COUNT_W) ? aw1 : COUNT_W) + 1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sorted_table_binary_search.sv =====
// Top level of the sorted table binary search block.
// Exact-match lookup in a table of identifiers kept sorted ascending. A request
// with command write stores its key at the given position (a position at or
// beyond TABLE_DEPTH is dropped) and gives no response; a request with command
// lookup gives one response with a found flag and the matching position (zero
// on a miss). The entry count register sets how many entries are searched and
// should only be written while no request is in flight. Requests enter a
// two-entry queue, so the block keeps taking requests while the search is busy
// or a response waits, until the queue is full. The back end does a write in
// its idle state. A lookup compares the key with the first and last entries,
// then runs binary search probes (at most about log2 of the entries in use,
// so at most 9 probes for a full 1024-entry table) and, if no probe matches,
// checks the start and end of the remaining range; keys outside the first and
// last entries finish without probes. The single-port table memory, read once
// per cycle, paces the search. Table entries must be written before a lookup reads them.
`default_nettype none

module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
   parameter int KEY_BITS    = stbs_pkg::DEFAULT_KEY_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [stbs_pkg::COUNT_W-1:0]  csr_entry_count,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_command,
   input  wire logic [stbs_pkg::POS_W-1:0]    req_position,
   input  wire logic [KEY_BITS-1:0]           req_key,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_found,
   output logic [stbs_pkg::POS_W-1:0]         rsp_match_position
);

   import stbs_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int IW = stbs_index_bits(TABLE_DEPTH);

   logic                 q_valid;
   stbs_op_type          q_op;
   logic signed [IW-1:0] q_index;
   logic [KEY_BITS-1:0]  q_key;
   logic                 q_pop;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_addr;
   logic [KEY_BITS-1:0]  ram_wr_data;
   logic [KEY_BITS-1:0]  ram_rd_data;

   // Request intake and queue.
   stbs_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_position (req_position),
      .req_key      (req_key),
      .q_valid      (q_valid),
      .q_op         (q_op),
      .q_index      (q_index),
      .q_key        (q_key),
      .q_pop        (q_pop)
   );

   // Table writes and the search sequencer.
   stbs_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_entry_count    (csr_entry_count),
      .q_valid            (q_valid),
      .q_op               (q_op),
      .q_index            (q_index),
      .q_key              (q_key),
      .q_pop              (q_pop),
      .ram_wr_en          (ram_wr_en),
      .ram_addr           (ram_addr),
      .ram_wr_data        (ram_wr_data),
      .ram_rd_data        (ram_rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_match_position (rsp_match_position)
   );

   // Identifier table.
   stbs_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// ===== rtl/stbs_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read of the same address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/stbs_front.sv =====
// Request front end: accepts and decodes requests into a short queue for the back end.
`default_nettype none

module stbs_front #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
   parameter int KEY_BITS    = stbs_pkg::DEFAULT_KEY_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_command,
   input  wire logic [stbs_pkg::POS_W-1:0]             req_position,
   input  wire logic [KEY_BITS-1:0]                    req_key,
   output logic                                        q_valid,
   output stbs_pkg::stbs_op_type                       q_op,
   output logic signed [stbs_pkg::stbs_index_bits(TABLE_DEPTH)-1:0] q_index,
   output logic [KEY_BITS-1:0]                         q_key,
   input  wire logic                                   q_pop
);

   import stbs_pkg::*;

   localparam int IW    = stbs_index_bits(TABLE_DEPTH);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

   stbs_op_type              op_q_ff  [QUEUE_DEPTH];
   logic signed [IW-1:0]     idx_q_ff [QUEUE_DEPTH];
   logic [KEY_BITS-1:0]      key_q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     push;
   stbs_op_type              op_dec;

   // Decode the incoming request; a write beyond the table is dropped later.
   always_comb begin
      op_dec.is_lookup = (req_command == CMD_LOOKUP);
      op_dec.write_ok  = (32'(req_position) < DEPTH32);
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Queue control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         op_q_ff[wr_ptr_ff]  <= op_dec;
         idx_q_ff[wr_ptr_ff] <= IW'(req_position);
         key_q_ff[wr_ptr_ff] <= req_key;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_op    = op_q_ff[rd_ptr_ff];
   assign q_index = idx_q_ff[rd_ptr_ff];
   assign q_key   = key_q_ff[rd_ptr_ff];

   // The back end only takes an entry that is present.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> (count_ff != '0))
      else $error("queue popped while empty");

   // Occupancy never exceeds the queue size.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy overflow");

endmodule

`default_nettype wire

// ===== rtl/stbs_back.sv =====
// Back end: table writes and the binary search sequencer with its result register.
`default_nettype none

module stbs_back #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
   parameter int KEY_BITS    = stbs_pkg::DEFAULT_KEY_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [stbs_pkg::COUNT_W-1:0]           csr_entry_count,
   input  wire logic                                   q_valid,
   input  wire stbs_pkg::stbs_op_type                  q_op,
   input  wire logic signed [stbs_pkg::stbs_index_bits(TABLE_DEPTH)-1:0] q_index,
   input  wire logic [KEY_BITS-1:0]                    q_key,
   output logic                                        q_pop,
   output logic                                        ram_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]              ram_addr,
   output logic [KEY_BITS-1:0]                         ram_wr_data,
   input  wire logic [KEY_BITS-1:0]                    ram_rd_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic                                        rsp_found,
   output logic [stbs_pkg::POS_W-1:0]                  rsp_match_position
);

   import stbs_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int IW = stbs_index_bits(TABLE_DEPTH);
   localparam logic [31:0]          DEPTH32 = 32'(TABLE_DEPTH);
   localparam logic signed [IW-1:0] IDX_ONE = IW'(1);

   stbs_state_type        state_ff, state_in;
   logic [COUNT_W-1:0]    count_ff;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic signed [IW-1:0]  n_ff, n_in;
   logic signed [IW-1:0]  start_ff, start_in;
   logic signed [IW-1:0]  end_ff, end_in;
   logic signed [IW-1:0]  mid_ff, mid_in;
   logic                  found_ff, found_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic [POS_W-1:0]      rsp_pos_ff;
   logic                  rsp_load;
   logic                  out_free;
   logic signed [IW-1:0]  n_calc;
   logic signed [IW-1:0]  last_idx;
   logic signed [IW-1:0]  s_new;
   logic signed [IW-1:0]  e_new;
   logic [IW:0]           mid_sum;
   logic signed [IW-1:0]  mid_next;
   logic                  keep_going;
   logic                  key_lt;
   logic                  key_gt;
   logic                  key_eq;
   logic                  s_new_ok;
   logic                  start_ok;
   logic                  end_ok;

   // Entry count register; it is always ready for a write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_entry_count;
      end
   end

   // Entries in use, with a count above the table depth clamped to the depth.
   assign n_calc   = (32'(count_ff) > DEPTH32) ? IW'(TABLE_DEPTH) : IW'(count_ff);
   assign last_idx = n_ff - IDX_ONE;

   // Compare the search key against the entry read in the previous cycle.
   assign key_lt = (key_ff < ram_rd_data);
   assign key_gt = (key_ff > ram_rd_data);
   assign key_eq = (key_ff == ram_rd_data);

   // Bounds after this probe; the last-entry check seeds the full range.
   always_comb begin
      if (state_ff == ST_LAST) begin
         s_new = '0;
         e_new = last_idx;
      end else if (key_gt) begin
         s_new = mid_ff + IDX_ONE;
         e_new = end_ff;
      end else begin
         s_new = start_ff;
         e_new = mid_ff - IDX_ONE;
      end
   end

   assign mid_sum    = {1'b0, s_new} + {1'b0, e_new};
   assign mid_next   = $signed(mid_sum[IW:1]);
   assign keep_going = ((e_new - s_new) > IDX_ONE);
   assign s_new_ok   = !s_new[IW-1] && (s_new < n_ff);
   assign start_ok   = !start_ff[IW-1] && (start_ff < n_ff);
   assign end_ok     = !end_ff[IW-1] && (end_ff < n_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_op.is_lookup) begin
               state_in = (n_calc == '0) ? ST_RESULT : ST_FIRST;
            end
         end
         ST_FIRST: begin
            state_in = key_lt ? ST_RESULT : ST_LAST;
         end
         ST_LAST: begin
            if (key_gt) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (key_eq) begin
               state_in = ST_RESULT;
            end else if (keep_going) begin
               state_in = ST_PROBE;
            end else begin
               state_in = ST_CHK_START;
            end
         end
         ST_CHK_START: begin
            state_in = (start_ok && key_eq) ? ST_RESULT : ST_CHK_END;
         end
         ST_CHK_END: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath updates per state.
   always_comb begin
      q_pop       = 1'b0;
      ram_wr_en   = 1'b0;
      ram_addr    = '0;
      ram_wr_data = q_key;
      rsp_load    = 1'b0;
      key_in      = key_ff;
      n_in        = n_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      mid_in      = mid_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            found_in = 1'b0;
            pos_in   = '0;
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_op.is_lookup) begin
                  key_in = q_key;
                  n_in   = n_calc;
               end else begin
                  ram_wr_en = q_op.write_ok;
                  ram_addr  = AW'(q_index);
               end
            end
         end
         ST_FIRST: begin
            ram_addr = AW'(last_idx);
         end
         ST_LAST: begin
            start_in = s_new;
            end_in   = e_new;
            mid_in   = mid_next;
            ram_addr = AW'(mid_next);
         end
         ST_PROBE: begin
            start_in = s_new;
            end_in   = e_new;
            if (key_eq) begin
               found_in = 1'b1;
               pos_in   = POS_W'(mid_ff);
            end else if (keep_going) begin
               mid_in   = mid_next;
               ram_addr = AW'(mid_next);
            end else begin
               ram_addr = s_new_ok ? AW'(s_new) : '0;
            end
         end
         ST_CHK_START: begin
            if (start_ok && key_eq) begin
               found_in = 1'b1;
               pos_in   = POS_W'(start_ff);
            end else begin
               ram_addr = end_ok ? AW'(end_ff) : '0;
            end
         end
         ST_CHK_END: begin
            if (end_ok && key_eq) begin
               found_in = 1'b1;
               pos_in   = POS_W'(end_ff);
            end
         end
         ST_RESULT: begin
            rsp_load = out_free;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Search datapath registers.
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      n_ff     <= n_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      mid_ff   <= mid_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
   end

   // Result register: the search may start the next request while it waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_pos_ff   <= pos_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_match_position = rsp_pos_ff;

   // While probing, the midpoint lies inside the live range and the range inside the table.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |->
         (!start_ff[IW-1] && (mid_ff >= start_ff) && (mid_ff <= end_ff) && (end_ff < n_ff)))
      else $error("search bounds out of order");

   // The table is written only between searches.
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_IDLE))
      else $error("table write during a search");

   // A miss reports position zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_position == '0))
      else $error("miss with nonzero position");

   // A finished search with a free result slot always shows a result next cycle.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RESULT) && out_free) |=> rsp_valid_ff)
      else $error("finished search lost its result");

endmodule

`default_nettype wire
